@@ hw/rtl/bmcs_pkg.sv @@
// Shared types and constants for the binary matrix checkerboard switch.
`timescale 1ns / 1ps

package bmcs_pkg;

  // Matrix store geometry
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths fixed by the item format
  localparam int CMD_W   = 3;
  localparam int LABEL_W = 7;
  localparam int REG_W   = 7;
  localparam int PROD_W  = LABEL_W + REG_W;
  localparam int POS_W   = PROD_W + 2;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_FLIP   = 3'd2,
    CMD_TEST   = 3'd3,
    CMD_SWITCH = 3'd4
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Resolved cell position
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } pos_t;

  // Store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              data;
  } mem_wr_t;

endpackage

@@ hw/rtl/bmcs_pos.sv @@
// Cell position computation and range check for one (row, column) pair.
`timescale 1ns / 1ps

module bmcs_pos import bmcs_pkg::*; (
  input  logic [LABEL_W-1:0]        row,
  input  logic signed [LABEL_W:0]   col,
  input  logic [REG_W-1:0]          num_rows,
  input  logic [REG_W-1:0]          num_cols,
  output pos_t                      pos
);

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       used;
  logic signed [POS_W-1:0] p;

  // p = row * stride + col, signed since col may be negative
  assign prod = PROD_W'(row) * PROD_W'(num_cols);
  assign used = PROD_W'(num_rows) * PROD_W'(num_cols);
  assign p    = $signed({2'b00, prod}) + $signed({{(POS_W-LABEL_W-1){col[LABEL_W]}}, col});

  // Valid when non-negative, inside the used matrix and inside the store
  assign pos.ok   = !p[POS_W-1]
                    && (p[POS_W-2:0] < {1'b0, used})
                    && (32'(p[POS_W-2:0]) < 32'(STORE_DEPTH));
  assign pos.addr = ADDR_W'(p[POS_W-2:0]);

endmodule

@@ hw/rtl/bmcs_ram.sv @@
// One-bit-wide matrix store with one write port and one registered read port.
`timescale 1ns / 1ps

module bmcs_ram import bmcs_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [STORE_DEPTH];
  logic rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/binary_matrix_checkerboard_switch_core.sv @@
// Top level: command sequencer, read-modify-write pipeline and output register.
// One command at a time: in_tready is high only in the idle state, and the store is read
//   one cell a cycle; a result held by out_tready stalls the next command.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all STORE_DEPTH (4096)
//   store entries with in_tready low; config writes are taken meanwhile.
`timescale 1ns / 1ps

module binary_matrix_checkerboard_switch_core import bmcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input requests
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // command[2:0], node_a[9:3], node_b[16:10],
                                           // node_c[23:17], node_d[30:24], bit_value[31]
  // Results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // read_bit[0], switchable[1], range_error[2],
                                           // zero[7:3]
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [REG_W-1:0]    num_rows_r, num_cols_r;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  // Request fields
  cmd_t                cmd_r, cmd_nxt;
  logic [LABEL_W-1:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic                val_r, val_nxt;

  // Resolved cells
  logic [ADDR_W-1:0]   addr_r [4];
  logic [ADDR_W-1:0]   addr_nxt [4];
  logic                err_r, err_nxt;
  logic [1:0]          k_r, k_nxt;
  logic                bits_r [4];
  logic                bits_nxt [4];

  // Read stage and write forwarding
  logic                rd_vld_r, rd_vld_nxt;
  logic [1:0]          rd_k_r, rd_k_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic                fw_vld_r, fw_vld_nxt;
  logic [ADDR_W-1:0]   fw_addr_r, fw_addr_nxt;
  logic                fw_data_r, fw_data_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_data_r, out_data_nxt;

  // Memory interface
  mem_wr_t             mem_wr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic                mem_q;
  logic                rd_data;

  // Position units
  pos_t                pos [4];
  logic                is_bit, is_cyc, rot, cells_ok, chk;
  logic [LABEL_W-1:0]  u1, u2, v1l, v2l;
  logic signed [LABEL_W:0] v1, v2, col0;

  bmcs_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_raddr),
    .rd_data (mem_q)
  );

  // Label rotation and column offset
  always_comb begin
    is_bit = (cmd_r == CMD_WRITE) || (cmd_r == CMD_READ) || (cmd_r == CMD_FLIP);
    is_cyc = (cmd_r == CMD_TEST) || (cmd_r == CMD_SWITCH);
    rot    = a_r > b_r;
    u1     = rot ? b_r : a_r;
    v1l    = rot ? c_r : b_r;
    u2     = rot ? d_r : c_r;
    v2l    = rot ? a_r : d_r;
    v1     = $signed({1'b0, v1l}) - $signed({1'b0, num_rows_r});
    v2     = $signed({1'b0, v2l}) - $signed({1'b0, num_rows_r});
    col0   = is_bit ? $signed({1'b0, b_r}) : v1;
  end

  bmcs_pos u_pos0 (.row(is_bit ? a_r : u1), .col(col0), .num_rows(num_rows_r),
                   .num_cols(num_cols_r), .pos(pos[0]));
  bmcs_pos u_pos1 (.row(u1), .col(v2), .num_rows(num_rows_r),
                   .num_cols(num_cols_r), .pos(pos[1]));
  bmcs_pos u_pos2 (.row(u2), .col(v1), .num_rows(num_rows_r),
                   .num_cols(num_cols_r), .pos(pos[2]));
  bmcs_pos u_pos3 (.row(u2), .col(v2), .num_rows(num_rows_r),
                   .num_cols(num_cols_r), .pos(pos[3]));

  assign cells_ok = is_bit ? pos[0].ok
                           : (pos[0].ok && pos[1].ok && pos[2].ok && pos[3].ok);

  // Read data with forwarding of the write made in the previous cycle
  assign rd_data = (fw_vld_r && (fw_addr_r == rd_addr_r)) ? fw_data_r : mem_q;

  // Checkerboard test on the four captured bits
  assign chk = (bits_r[0] == bits_r[3]) && (bits_r[1] == bits_r[2])
               && (bits_r[0] != bits_r[1]);

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= REG_W'(64);
      num_cols_r <= REG_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_r <= cfg_data;
        CFG_NUM_COLS: num_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    val_nxt       = val_r;
    addr_nxt      = addr_r;
    err_nxt       = err_r;
    k_nxt         = k_r;
    bits_nxt      = bits_r;
    rd_vld_nxt    = 1'b0;
    rd_k_nxt      = rd_k_r;
    rd_addr_nxt   = rd_addr_r;
    fw_vld_nxt    = 1'b0;
    fw_addr_nxt   = fw_addr_r;
    fw_data_nxt   = fw_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_wr        = '0;
    mem_raddr     = addr_r[k_r];
    in_tready     = 1'b0;

    // Result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Read stage: capture bit, write back flipped value for flip and switch
    if (rd_vld_r) begin
      bits_nxt[rd_k_r] = rd_data;
      if ((cmd_r == CMD_FLIP) || (cmd_r == CMD_SWITCH)) begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = rd_addr_r;
        mem_wr.data = !rd_data;
        fw_vld_nxt  = 1'b1;
        fw_addr_nxt = rd_addr_r;
        fw_data_nxt = !rd_data;
      end
    end

    case (state_r)
      // Zero the store one entry a cycle
      ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_cnt_r;
        mem_wr.data = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      // Wait for a request
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tdata[2:0]);
          a_nxt     = in_tdata[9:3];
          b_nxt     = in_tdata[16:10];
          c_nxt     = in_tdata[23:17];
          d_nxt     = in_tdata[30:24];
          val_nxt   = in_tdata[31];
          state_nxt = ST_CALC;
        end
      end
      // Resolve cell positions and range
      ST_CALC: begin
        for (int i = 0; i < 4; i++) begin
          addr_nxt[i] = pos[i].addr;
        end
        k_nxt   = 2'd0;
        err_nxt = (is_bit || is_cyc) && !cells_ok;
        if ((is_bit || is_cyc) && cells_ok) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      // Issue one cell access a cycle
      ST_ACC: begin
        if (cmd_r == CMD_WRITE) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = addr_r[0];
          mem_wr.data = val_r;
          state_nxt   = ST_FIN;
        end else begin
          rd_vld_nxt  = 1'b1;
          rd_k_nxt    = k_r;
          rd_addr_nxt = addr_r[k_r];
          k_nxt       = k_r + 1'b1;
          if (is_bit || (k_r == 2'd3)) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      // Last read completes
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      // Load the result once the output register is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_data_nxt[0] = (cmd_r == CMD_READ) && !err_r && bits_r[0];
          out_data_nxt[1] = (cmd_r == CMD_TEST) && !err_r && chk;
          out_data_nxt[2] = err_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      fw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fw_vld_r    <= fw_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    val_r      <= val_nxt;
    addr_r     <= addr_nxt;
    err_r      <= err_nxt;
    k_r        <= k_nxt;
    bits_r     <= bits_nxt;
    rd_k_r     <= rd_k_nxt;
    rd_addr_r  <= rd_addr_nxt;
    fw_addr_r  <= fw_addr_nxt;
    fw_data_r  <= fw_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_data_r};

endmodule
